// ----- rtl/core/ctt_pkg.sv -----
// Shared types, constants and state encoding for the centroid track table.
// Used by ctt_engine and centroid_track_table_core; no dependencies.
`default_nettype none
package ctt_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int DEPTH      = 2 * MAX_TRACKS;
    localparam int COORD_W    = 16;
    localparam int LIVE_W     = 6;
    localparam int MOVE_W     = 17;

    localparam logic [15:0] RADIUS_RESET = 16'd800;
    localparam logic [7:0]  LOSS_RESET   = 8'd10;
    localparam logic [7:0]  REG_RADIUS   = 8'd0;
    localparam logic [7:0]  REG_LOSS     = 8'd1;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_NEW   = 2'd1,
        KIND_DROP  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_SCAN_RD,
        ST_SCAN_DX,
        ST_SCAN_DY,
        ST_SCAN_CMP,
        ST_NEW,
        ST_SW_RD,
        ST_SW_WR,
        ST_SWAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] id;
        logic [15:0] seen;
        logic [7:0]  missed;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic        point_present;
        logic        frame_end;
    } item_t;

    typedef struct packed {
        kind_t              result_kind;
        logic [15:0]        track_number;
        logic [15:0]        seen_frames;
        logic [MOVE_W-1:0]  moved_x;
        logic [MOVE_W-1:0]  moved_y;
        logic [LIVE_W-1:0]  live_tracks;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/centroid_track_table_core.sv -----
// Top level of the centroid track table: configuration registers, output register,
// track store. Depends on ctt_pkg, ctt_ram and ctt_engine.
//
// Usage: centroids enter on the s_ channel, one request each; s_tlast marks the
// last request of a video frame, and a request with point_present low carries no
// centroid. Each request yields exactly one result on the m_ channel, with the
// result kind in m_tuser. The cfg_ channel writes match_radius (index 0) and
// loss_limit (index 1) and is always ready; write it only while the block is idle.
// A centroid's time grows with each unmatched track scanned and each track already
// taken in this frame; a frame end adds a sweep over every track of the table.
// The scan through the single-read-port track store and the shared squaring
// multiplier set how long a request takes.
// s_tready is high only while the sequencer is idle, one request at a time.
// A finished result waits in the output register; the next request is taken
// while it waits, and the sequencer holds its second result until m_tready frees
// the register. Reset empties the table, clears the id counter, restores the
// register defaults and empties the output register.
`default_nettype none
module centroid_track_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // point_x[15:0], point_y[31:16], point_present[32], zero
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // track_number, seen_frames, moved_x, moved_y, live_tracks
    output logic      [1:0]  m_tuser,   // result_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]       radius_reg;
    logic [7:0]        loss_reg;
    logic              m_valid_reg;
    ctt_pkg::result_t  out_reg;
    ctt_pkg::item_t    item;
    ctt_pkg::result_t  res;
    ctt_pkg::ram_req_t ram_req;
    ctt_pkg::entry_t   ram_rdata;
    logic              res_valid, out_free;

    assign item.point_x       = s_tdata[15:0];
    assign item.point_y       = s_tdata[31:16];
    assign item.point_present = s_tdata[32];
    assign item.frame_end     = s_tlast;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= ctt_pkg::RADIUS_RESET;
            loss_reg    <= ctt_pkg::LOSS_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == ctt_pkg::REG_RADIUS)
                radius_reg <= cfg_data;
            if (cfg_valid && cfg_index == ctt_pkg::REG_LOSS)
                loss_reg <= cfg_data[7:0];
            if (res_valid)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {out_reg.live_tracks, out_reg.moved_y, out_reg.moved_x,
                       out_reg.seen_frames, out_reg.track_number};

    ctt_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (item),
        .match_radius (radius_reg),
        .loss_limit   (loss_reg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    ctt_ram #(
        .WIDTH (ctt_pkg::ENTRY_W),
        .DEPTH (ctt_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ----- rtl/core/ctt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/ctt_engine.sv -----
// Sequencer and shared squaring unit: table scan, track refresh and frame-end sweep.
// Depends on ctt_pkg; drives the track store through a ram_req_t request.
`default_nettype none
module ctt_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ctt_pkg::item_t    in_item,
    input  wire logic [15:0]       match_radius,
    input  wire logic [7:0]        loss_limit,
    input  wire logic              out_free,
    output logic                   res_valid,
    output ctt_pkg::result_t       res,
    output ctt_pkg::ram_req_t      ram_req,
    input  wire ctt_pkg::entry_t   ram_rdata
);

    ctt_pkg::state_t state_reg, state_next;

    logic [ctt_pkg::CNT_W-1:0]      idx_reg, next_fill_reg, cur_fill_reg;
    logic                           bank_reg;
    logic [15:0]                    id_counter_reg;
    logic [ctt_pkg::MAX_TRACKS-1:0] hit_reg;

    ctt_pkg::item_t   item_reg;
    ctt_pkg::entry_t  ent_reg;
    ctt_pkg::result_t res_reg;
    logic [31:0]      acc_reg, prod_reg, r2_reg;

    logic [ctt_pkg::IDX_W-1:0]  idx;
    logic                       scan_end, next_full, hit_now, is_match;
    logic [15:0]                mul_a;
    logic [31:0]                mul_p;
    logic [32:0]                dist_sum;
    logic [7:0]                 miss_inc;
    logic                       keep;
    logic [ctt_pkg::ADDR_W-1:0] cur_addr, nxt_addr;
    ctt_pkg::entry_t            match_ent, new_ent, age_ent;
    ctt_pkg::result_t           start_res;
    logic [15:0]                seen_inc;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [ctt_pkg::MOVE_W-1:0] disp(input logic [15:0] p,
                                                       input logic [15:0] s);
        disp = {1'b0, p} - {1'b0, s};
    endfunction

    assign idx       = idx_reg[ctt_pkg::IDX_W-1:0];
    assign scan_end  = idx_reg >= cur_fill_reg;
    assign next_full = next_fill_reg >= ctt_pkg::CNT_W'(ctt_pkg::MAX_TRACKS);
    assign hit_now   = hit_reg[idx];
    assign cur_addr  = {bank_reg, idx};
    assign nxt_addr  = {~bank_reg, next_fill_reg[ctt_pkg::IDX_W-1:0]};
    assign mul_p     = mul_a * mul_a;
    assign dist_sum  = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign is_match  = dist_sum < {1'b0, r2_reg};
    assign miss_inc  = (ram_rdata.missed == 8'hFF) ? 8'hFF : ram_rdata.missed + 8'd1;
    assign keep      = (miss_inc < loss_limit) && !next_full;
    assign seen_inc  = (ent_reg.seen == 16'hFFFF) ? 16'hFFFF : ent_reg.seen + 16'd1;

    always_comb
    begin
        match_ent         = ent_reg;
        match_ent.pos_x   = item_reg.point_x;
        match_ent.pos_y   = item_reg.point_y;
        match_ent.seen    = seen_inc;
        match_ent.missed  = 8'd0;
        new_ent.pos_x     = item_reg.point_x;
        new_ent.pos_y     = item_reg.point_y;
        new_ent.start_x   = item_reg.point_x;
        new_ent.start_y   = item_reg.point_y;
        new_ent.id        = id_counter_reg;
        new_ent.seen      = 16'd1;
        new_ent.missed    = 8'd0;
        age_ent           = ram_rdata;
        age_ent.missed    = miss_inc;
        start_res             = '0;
        start_res.result_kind = !in_item.point_present ? ctt_pkg::KIND_NONE :
                                next_full ? ctt_pkg::KIND_DROP : ctt_pkg::KIND_MATCH;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.point_present && !next_full)
                        state_next = ctt_pkg::ST_R2;
                    else if (in_item.frame_end)
                        state_next = ctt_pkg::ST_SW_RD;
                    else
                        state_next = ctt_pkg::ST_DONE;
                end
            end
            ctt_pkg::ST_R2:      state_next = ctt_pkg::ST_SCAN_RD;
            ctt_pkg::ST_SCAN_RD:
            begin
                if (scan_end)
                    state_next = ctt_pkg::ST_NEW;
                else if (!hit_now)
                    state_next = ctt_pkg::ST_SCAN_DX;
            end
            ctt_pkg::ST_SCAN_DX: state_next = ctt_pkg::ST_SCAN_DY;
            ctt_pkg::ST_SCAN_DY: state_next = ctt_pkg::ST_SCAN_CMP;
            ctt_pkg::ST_SCAN_CMP:
            begin
                if (!is_match)
                    state_next = ctt_pkg::ST_SCAN_RD;
                else if (item_reg.frame_end)
                    state_next = ctt_pkg::ST_SW_RD;
                else
                    state_next = ctt_pkg::ST_DONE;
            end
            ctt_pkg::ST_NEW:
                state_next = item_reg.frame_end ? ctt_pkg::ST_SW_RD : ctt_pkg::ST_DONE;
            ctt_pkg::ST_SW_RD:
            begin
                if (scan_end)
                    state_next = ctt_pkg::ST_SWAP;
                else if (!hit_now)
                    state_next = ctt_pkg::ST_SW_WR;
            end
            ctt_pkg::ST_SW_WR:   state_next = ctt_pkg::ST_SW_RD;
            ctt_pkg::ST_SWAP:    state_next = ctt_pkg::ST_DONE;
            ctt_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = ctt_pkg::ST_IDLE;
            end
            default:             state_next = ctt_pkg::ST_IDLE;
        endcase
    end

    // Outputs: handshake, multiplier operand and store request.
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mul_a         = match_radius;
        ram_req.we    = 1'b0;
        ram_req.waddr = nxt_addr;
        ram_req.wdata = new_ent;
        ram_req.raddr = cur_addr;
        unique case (state_reg)
            ctt_pkg::ST_IDLE:     in_ready = 1'b1;
            ctt_pkg::ST_SCAN_DX:  mul_a = abs_diff(item_reg.point_x, ram_rdata.pos_x);
            ctt_pkg::ST_SCAN_DY:  mul_a = abs_diff(item_reg.point_y, ent_reg.pos_y);
            ctt_pkg::ST_SCAN_CMP:
            begin
                ram_req.we    = is_match;
                ram_req.wdata = match_ent;
            end
            ctt_pkg::ST_NEW:      ram_req.we = 1'b1;
            ctt_pkg::ST_SW_WR:
            begin
                ram_req.we    = keep;
                ram_req.wdata = age_ent;
            end
            ctt_pkg::ST_DONE:     res_valid = out_free;
            default: ;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ctt_pkg::ST_IDLE;
            idx_reg        <= '0;
            next_fill_reg  <= '0;
            cur_fill_reg   <= '0;
            bank_reg       <= 1'b0;
            id_counter_reg <= '0;
            hit_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ctt_pkg::ST_IDLE:    idx_reg <= '0;
                ctt_pkg::ST_SCAN_RD,
                ctt_pkg::ST_SW_RD:
                begin
                    if (!scan_end && hit_now)
                        idx_reg <= idx_reg + 1'b1;
                end
                ctt_pkg::ST_SCAN_CMP:
                begin
                    if (is_match)
                    begin
                        hit_reg[idx]  <= 1'b1;
                        next_fill_reg <= next_fill_reg + 1'b1;
                        idx_reg       <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ctt_pkg::ST_NEW:
                begin
                    next_fill_reg  <= next_fill_reg + 1'b1;
                    id_counter_reg <= id_counter_reg + 16'd1;
                    idx_reg        <= '0;
                end
                ctt_pkg::ST_SW_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (keep)
                        next_fill_reg <= next_fill_reg + 1'b1;
                end
                ctt_pkg::ST_SWAP:
                begin
                    bank_reg      <= ~bank_reg;
                    cur_fill_reg  <= next_fill_reg;
                    next_fill_reg <= '0;
                    hit_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                item_reg <= in_item;
                res_reg  <= start_res;
            end
            ctt_pkg::ST_R2:      r2_reg <= mul_p;
            ctt_pkg::ST_SCAN_DX:
            begin
                ent_reg <= ram_rdata;
                acc_reg <= mul_p;
            end
            ctt_pkg::ST_SCAN_DY: prod_reg <= mul_p;
            ctt_pkg::ST_SCAN_CMP:
            begin
                if (is_match)
                begin
                    res_reg.result_kind  <= ctt_pkg::KIND_MATCH;
                    res_reg.track_number <= ent_reg.id;
                    res_reg.seen_frames  <= seen_inc;
                    res_reg.moved_x      <= disp(item_reg.point_x, ent_reg.start_x);
                    res_reg.moved_y      <= disp(item_reg.point_y, ent_reg.start_y);
                end
            end
            ctt_pkg::ST_NEW:
            begin
                res_reg.result_kind  <= ctt_pkg::KIND_NEW;
                res_reg.track_number <= id_counter_reg;
                res_reg.seen_frames  <= 16'd1;
                res_reg.moved_x      <= '0;
                res_reg.moved_y      <= '0;
            end
            ctt_pkg::ST_SWAP:    res_reg.live_tracks <= ctt_pkg::LIVE_W'(next_fill_reg);
            default: ;
        endcase
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_fill_reg <= ctt_pkg::CNT_W'(ctt_pkg::MAX_TRACKS))
        else $error("next table fill exceeds capacity");

    a_write_next_bank: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (ram_req.waddr[ctt_pkg::ADDR_W-1] != bank_reg))
        else $error("store write landed in the current bank");

    a_swap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ctt_pkg::ST_SWAP |=> hit_reg == '0 && next_fill_reg == '0)
        else $error("frame swap left marks or fill behind");

    a_match_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctt_pkg::ST_SCAN_CMP && is_match) |=> hit_reg[$past(idx)])
        else $error("matched track not marked");

endmodule
`default_nettype wire
